@@ src/sbc_pkg.sv @@
// Shared types and codes for the sector buffer cache manager.
`timescale 1ns / 1ps

package sbc_pkg;

  localparam int unsigned SECTOR_W = 32;
  localparam int unsigned SLOT_W   = 6;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FLUSH   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_FILL_FREE  = 3'd1,
    ST_FILL_EVICT = 3'd2,
    ST_STALL      = 3'd3,
    ST_RELEASED   = 3'd4,
    ST_REL_ERROR  = 3'd5,
    ST_FLUSH_ITEM = 3'd6,
    ST_FLUSH_DONE = 3'd7
  } status_e;

  typedef struct packed {
    logic                valid;
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] victim;
    logic                wb;
    logic                last;
  } result_t;

endpackage

@@ src/sbc_ram.sv @@
// Single-port-write, registered-read memory used for slot entries and order links.
`timescale 1ns / 1ps

module sbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sbc_ctrl.sv @@
// Sequencer: tag scan, clock-hand eviction, release and flush over the slot memories.
`timescale 1ns / 1ps

module sbc_ctrl #(
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned COUNT_BITS = 8,
  localparam int unsigned SW = $clog2(SLOTS),
  localparam int unsigned EW = sbc_pkg::SECTOR_W + 1 + 2 * COUNT_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [1:0]                        op_i,
  input  logic [sbc_pkg::SECTOR_W-1:0]      sector_i,
  input  logic                              for_write_i,
  input  logic [sbc_pkg::SLOT_W-1:0]        slot_in_i,
  output logic                              busy_o,
  output sbc_pkg::result_t                  res_o,
  output logic [SW-1:0]                     rd_addr_o,
  output logic                              e_we_o,
  output logic [SW-1:0]                     e_waddr_o,
  output logic [EW-1:0]                     e_wdata_o,
  input  logic [EW-1:0]                     e_rdata_i,
  output logic                              l_we_o,
  output logic [SW-1:0]                     l_waddr_o,
  output logic [SW-1:0]                     l_wdata_o,
  input  logic [SW-1:0]                     l_rdata_i
);

  import sbc_pkg::*;

  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam int unsigned CB = COUNT_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_HSCAN, S_WALK, S_FINDP, S_RELINK, S_REL, S_FLUSH, S_FDONE
  } state_e;

  state_e              state_q, state_d;
  logic [SW-1:0]       cur_q, cur_d;
  logic [LW-1:0]       n_q, n_d;
  logic [SW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [LW-1:0]       len_q, len_d;
  logic                hand_vld_q, hand_vld_d;
  logic [SW-1:0]       hand_q, hand_d;
  logic [SLOTS-1:0]    used_q, used_d;
  logic [SECTOR_W-1:0] sector_q, sector_d;
  logic                wr_q, wr_d;
  logic [SW-1:0]       vic_q, vic_d, vic_next_q, vic_next_d;
  logic [SECTOR_W-1:0] vic_tag_q, vic_tag_d;
  logic                vic_dirty_q, vic_dirty_d;
  result_t             res_q, res_d;

  logic [SECTOR_W-1:0] r_tag;
  logic                r_dirty;
  logic [CB-1:0]       r_rc, r_wc, cnt;
  logic [EW-1:0]       fill_word;
  logic                free_found;
  logic [SW-1:0]       free_idx;

  assign r_tag   = e_rdata_i[EW-1 -: SECTOR_W];
  assign r_dirty = e_rdata_i[2*CB];
  assign r_rc    = e_rdata_i[2*CB-1:CB];
  assign r_wc    = e_rdata_i[CB-1:0];
  assign cnt     = wr_q ? r_wc : r_rc;
  assign fill_word = {sector_q, 1'b0, (wr_q ? CB'(0) : CB'(1)), (wr_q ? CB'(1) : CB'(0))};

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    n_d         = n_q;
    head_d      = head_q;
    tail_d      = tail_q;
    len_d       = len_q;
    hand_vld_d  = hand_vld_q;
    hand_d      = hand_q;
    used_d      = used_q;
    sector_d    = sector_q;
    wr_d        = wr_q;
    vic_d       = vic_q;
    vic_next_d  = vic_next_q;
    vic_tag_d   = vic_tag_q;
    vic_dirty_d = vic_dirty_q;
    res_d       = '0;
    e_we_o      = 1'b0;
    e_waddr_o   = cur_q;
    e_wdata_o   = e_rdata_i;
    l_we_o      = 1'b0;
    l_waddr_o   = tail_q;
    l_wdata_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          sector_d = sector_i;
          wr_d     = for_write_i;
          case (op_i)
            OP_ACQUIRE: begin
              cur_d   = '0;
              state_d = S_HSCAN;
            end
            OP_RELEASE: begin
              if ({1'b0, slot_in_i} >= (SLOT_W + 1)'(SLOTS) || !used_q[slot_in_i[SW-1:0]]) begin
                res_d.valid  = 1'b1;
                res_d.status = ST_REL_ERROR;
                res_d.slot   = slot_in_i;
                res_d.last   = 1'b1;
              end else begin
                cur_d   = slot_in_i[SW-1:0];
                state_d = S_REL;
              end
            end
            OP_FLUSH: begin
              n_d = '0;
              if (len_q == '0) begin
                res_d.valid  = 1'b1;
                res_d.status = ST_FLUSH_DONE;
                res_d.last   = 1'b1;
              end else begin
                cur_d   = head_q;
                state_d = S_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end

      S_HSCAN: begin
        if (used_q[cur_q] && r_tag == sector_q) begin
          res_d.valid = 1'b1;
          res_d.last  = 1'b1;
          if (&cnt) begin
            res_d.status = ST_STALL;
          end else begin
            e_we_o       = 1'b1;
            e_wdata_o    = {r_tag, r_dirty,
                            (wr_q ? r_rc : r_rc + CB'(1)),
                            (wr_q ? r_wc + CB'(1) : r_wc)};
            res_d.status = ST_HIT;
            res_d.slot   = SLOT_W'(cur_q);
          end
          state_d = S_IDLE;
        end else if (cur_q == SW'(SLOTS - 1)) begin
          if (free_found) begin
            e_we_o           = 1'b1;
            e_waddr_o        = free_idx;
            e_wdata_o        = fill_word;
            used_d[free_idx] = 1'b1;
            if (len_q == '0) begin
              head_d = free_idx;
            end else begin
              l_we_o    = 1'b1;
              l_wdata_o = free_idx;
            end
            tail_d       = free_idx;
            len_d        = len_q + LW'(1);
            res_d.valid  = 1'b1;
            res_d.status = ST_FILL_FREE;
            res_d.slot   = SLOT_W'(free_idx);
            res_d.last   = 1'b1;
            state_d      = S_IDLE;
          end else begin
            cur_d   = hand_vld_q ? hand_q : head_q;
            n_d     = '0;
            state_d = S_WALK;
          end
        end else begin
          cur_d = cur_q + SW'(1);
        end
      end

      S_WALK: begin
        if (r_rc == '0 && r_wc == '0) begin
          vic_d       = cur_q;
          vic_tag_d   = r_tag;
          vic_dirty_d = r_dirty;
          vic_next_d  = l_rdata_i;
          if (cur_q == tail_q) begin
            hand_vld_d = 1'b0;
            hand_d     = '0;
          end else begin
            hand_vld_d = 1'b1;
            hand_d     = l_rdata_i;
          end
          e_we_o    = 1'b1;
          e_wdata_o = fill_word;
          if (cur_q == head_q) begin
            // victim at front: unlink by moving head, rejoin at tail
            head_d       = l_rdata_i;
            l_we_o       = 1'b1;
            l_wdata_o    = cur_q;
            tail_d       = cur_q;
            res_d.valid  = 1'b1;
            res_d.status = ST_FILL_EVICT;
            res_d.slot   = SLOT_W'(cur_q);
            res_d.victim = r_tag;
            res_d.wb     = r_dirty;
            res_d.last   = 1'b1;
            state_d      = S_IDLE;
          end else begin
            cur_d   = head_q;
            state_d = S_FINDP;
          end
        end else if ((n_q + LW'(1)) == len_q) begin
          res_d.valid  = 1'b1;
          res_d.status = ST_STALL;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          n_d   = n_q + LW'(1);
          cur_d = (cur_q == tail_q) ? head_q : l_rdata_i;
        end
      end

      S_FINDP: begin
        if (l_rdata_i == vic_q) begin
          l_we_o    = 1'b1;
          l_waddr_o = cur_q;
          if (vic_q == tail_q) begin
            // predecessor becomes tail, victim rejoins right behind it
            l_wdata_o    = vic_q;
            res_d.valid  = 1'b1;
            res_d.status = ST_FILL_EVICT;
            res_d.slot   = SLOT_W'(vic_q);
            res_d.victim = vic_tag_q;
            res_d.wb     = vic_dirty_q;
            res_d.last   = 1'b1;
            state_d      = S_IDLE;
          end else begin
            l_wdata_o = vic_next_q;
            state_d   = S_RELINK;
          end
        end else begin
          cur_d = l_rdata_i;
        end
      end

      S_RELINK: begin
        l_we_o       = 1'b1;
        l_wdata_o    = vic_q;
        tail_d       = vic_q;
        res_d.valid  = 1'b1;
        res_d.status = ST_FILL_EVICT;
        res_d.slot   = SLOT_W'(vic_q);
        res_d.victim = vic_tag_q;
        res_d.wb     = vic_dirty_q;
        res_d.last   = 1'b1;
        state_d      = S_IDLE;
      end

      S_REL: begin
        res_d.valid = 1'b1;
        res_d.slot  = SLOT_W'(cur_q);
        res_d.last  = 1'b1;
        if (cnt == '0) begin
          res_d.status = ST_REL_ERROR;
        end else begin
          e_we_o       = 1'b1;
          e_wdata_o    = {r_tag, (r_dirty | wr_q),
                          (wr_q ? r_rc : r_rc - CB'(1)),
                          (wr_q ? r_wc - CB'(1) : r_wc)};
          res_d.status = ST_RELEASED;
        end
        state_d = S_IDLE;
      end

      S_FLUSH: begin
        if (r_dirty) begin
          e_we_o       = 1'b1;
          e_wdata_o    = {r_tag, 1'b0, r_rc, r_wc};
          res_d.valid  = 1'b1;
          res_d.status = ST_FLUSH_ITEM;
          res_d.slot   = SLOT_W'(cur_q);
          res_d.victim = r_tag;
          res_d.wb     = 1'b1;
        end
        n_d = n_q + LW'(1);
        if ((n_q + LW'(1)) == len_q) begin
          state_d = S_FDONE;
        end else begin
          cur_d = l_rdata_i;
        end
      end

      S_FDONE: begin
        res_d.valid  = 1'b1;
        res_d.status = ST_FLUSH_DONE;
        res_d.last   = 1'b1;
        state_d      = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cur_q      <= '0;
      n_q        <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      len_q      <= '0;
      hand_vld_q <= 1'b0;
      hand_q     <= '0;
      used_q     <= '0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      n_q        <= n_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      len_q      <= len_d;
      hand_vld_q <= hand_vld_d;
      hand_q     <= hand_d;
      used_q     <= used_d;
      res_q      <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sector_q    <= sector_d;
    wr_q        <= wr_d;
    vic_q       <= vic_d;
    vic_next_q  <= vic_next_d;
    vic_tag_q   <= vic_tag_d;
    vic_dirty_q <= vic_dirty_d;
  end

  // memories always read the address whose data the next state consumes
  assign rd_addr_o = cur_d;
  assign busy_o    = (state_q != S_IDLE);
  assign res_o     = res_q;

endmodule

@@ src/sector_buffer_cache_manager_top.sv @@
// Top level of the sector buffer cache manager: slot memories and sequencer.
`timescale 1ns / 1ps

// Tag manager for a fully associative sector cache with clock eviction. A command is
// taken when start_i is high and busy_o is low; every result appears for one cycle with
// valid_o high and cannot be held off, and last_o marks the final result of a command.
// Slot entries (tag, dirty bit, reader and writer counts) and fill-order links sit in two
// memories with one registered read per cycle. An acquire runs a tag scan, and a miss
// with eviction then a hand walk and a predecessor search; a flush walks the fill order
// one member at a time. Results of a flush come at most one per cycle. Slot-in-use bits
// and list pointers clear at reset; no memory clearing is needed.

module sector_buffer_cache_manager_top #(
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   op_i,
  input  logic [sbc_pkg::SECTOR_W-1:0] sector_i,
  input  logic                         for_write_i,
  input  logic [sbc_pkg::SLOT_W-1:0]   slot_in_i,
  output logic                         valid_o,
  output logic [2:0]                   status_o,
  output logic [sbc_pkg::SLOT_W-1:0]   slot_o,
  output logic [sbc_pkg::SECTOR_W-1:0] victim_sector_o,
  output logic                         write_back_o,
  output logic                         last_o
);

  import sbc_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned EW = SECTOR_W + 1 + 2 * COUNT_BITS;

  logic [SW-1:0] rd_addr;
  logic          e_we, l_we;
  logic [SW-1:0] e_waddr, l_waddr, l_wdata, l_rdata;
  logic [EW-1:0] e_wdata, e_rdata;
  result_t       res;

  sbc_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (rd_addr),
    .rdata_o (e_rdata)
  );

  sbc_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (rd_addr),
    .rdata_o (l_rdata)
  );

  sbc_ctrl #(.SLOTS(SLOTS), .COUNT_BITS(COUNT_BITS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .op_i        (op_i),
    .sector_i    (sector_i),
    .for_write_i (for_write_i),
    .slot_in_i   (slot_in_i),
    .busy_o      (busy_o),
    .res_o       (res),
    .rd_addr_o   (rd_addr),
    .e_we_o      (e_we),
    .e_waddr_o   (e_waddr),
    .e_wdata_o   (e_wdata),
    .e_rdata_i   (e_rdata),
    .l_we_o      (l_we),
    .l_waddr_o   (l_waddr),
    .l_wdata_o   (l_wdata),
    .l_rdata_i   (l_rdata)
  );

  assign valid_o         = res.valid;
  assign status_o        = res.status;
  assign slot_o          = res.slot;
  assign victim_sector_o = res.victim;
  assign write_back_o    = res.wb;
  assign last_o          = res.last;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the sector buffer cache manager.
`timescale 1ns / 1ps

module tb;
  import sbc_pkg::*;

  localparam int NSLOT = 64;
  localparam int CNT_MAX = 255;
  localparam int WD_LIMIT = 20000;
  localparam int TAIL_CYCLES = 3 * NSLOT + 20;

  typedef struct {
    status_e     st;
    logic [5:0]  slot;
    logic [31:0] vs;
    logic        wb;
    logic        last;
  } cache_res_t;

  typedef struct {
    op_e         op;
    logic [31:0] sector;
    logic        wr;
    logic [5:0]  slot;
    bit          typed;
    status_e     st;
    logic [5:0]  eslot;
  } dir_row_t;

  logic        clk_i, rst_ni, start_i, busy_o;
  logic [1:0]  op_i;
  logic [31:0] sector_i;
  logic        for_write_i;
  logic [5:0]  slot_in_i;
  logic        valid_o;
  logic [2:0]  status_o;
  logic [5:0]  slot_o;
  logic [31:0] victim_sector_o;
  logic        write_back_o, last_o;

  sector_buffer_cache_manager_top dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .sector_i, .for_write_i, .slot_in_i,
    .valid_o, .status_o, .slot_o, .victim_sector_o, .write_back_o, .last_o
  );

  // shadow cache state
  logic [31:0] m_tag [NSLOT];
  bit          m_used [NSLOT];
  bit          m_dirty [NSLOT];
  int          m_rd [NSLOT];
  int          m_wr [NSLOT];
  int          m_next [NSLOT];
  int          m_head, m_tail, m_len;
  bit          m_hand_v;
  int          m_hand;

  cache_res_t  pending_res[$];
  cache_res_t  step_res[$];
  int          n_err = 0;
  int          n_items = 0, n_results = 0, n_evict = 0, n_stall = 0, n_flush = 0;
  int          idle_cyc = 0;
  bit          idle_en = 1;
  bit          timed_out = 0;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void add_res(status_e st, int sl, logic [31:0] vs, logic wb, logic last);
    cache_res_t r;
    r.st = st; r.slot = sl[5:0]; r.vs = vs; r.wb = wb; r.last = last;
    step_res.push_back(r);
  endfunction

  function automatic void fill_slot(int s, logic [31:0] sec, bit wr);
    m_tag[s] = sec; m_used[s] = 1; m_dirty[s] = 0;
    m_rd[s] = wr ? 0 : 1;
    m_wr[s] = wr ? 1 : 0;
    if (m_len == 0) m_head = s;
    else m_next[m_tail] = s;
    m_tail = s;
    m_len++;
  endfunction

  function automatic void unlink_slot(int v);
    int p;
    if (v == m_head) begin
      m_head = m_next[v];
    end else begin
      p = m_head;
      for (int i = 0; i < m_len; i++) begin
        if (m_next[p] == v) break;
        p = m_next[p];
      end
      m_next[p] = m_next[v];
      if (v == m_tail) m_tail = p;
    end
    m_len--;
  endfunction

  // computes the results of one transaction into step_res and updates the shadow state
  function automatic void cache_predict(op_e op, logic [31:0] sec, bit wr, int sl);
    int cur;
    step_res.delete();
    case (op)
      OP_ACQUIRE: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (m_used[i] && m_tag[i] == sec) begin
            if ((wr ? m_wr[i] : m_rd[i]) >= CNT_MAX) begin
              add_res(ST_STALL, 0, 0, 0, 1);
            end else begin
              if (wr) m_wr[i]++;
              else m_rd[i]++;
              add_res(ST_HIT, i, 0, 0, 1);
            end
            return;
          end
        end
        for (int i = 0; i < NSLOT; i++) begin
          if (!m_used[i]) begin
            fill_slot(i, sec, wr);
            add_res(ST_FILL_FREE, i, 0, 0, 1);
            return;
          end
        end
        cur = m_hand_v ? m_hand : m_head;
        for (int n = 0; n < m_len; n++) begin
          if (m_rd[cur] == 0 && m_wr[cur] == 0) begin
            add_res(ST_FILL_EVICT, cur, m_tag[cur], m_dirty[cur], 1);
            if (cur == m_tail) begin
              m_hand_v = 0; m_hand = 0;
            end else begin
              m_hand_v = 1; m_hand = m_next[cur];
            end
            unlink_slot(cur);
            fill_slot(cur, sec, wr);
            return;
          end
          cur = (cur == m_tail) ? m_head : m_next[cur];
        end
        add_res(ST_STALL, 0, 0, 0, 1);
      end
      OP_RELEASE: begin
        if (!m_used[sl] || (wr ? m_wr[sl] : m_rd[sl]) == 0) begin
          add_res(ST_REL_ERROR, sl, 0, 0, 1);
        end else begin
          if (wr) begin
            m_wr[sl]--;
            m_dirty[sl] = 1;
          end else begin
            m_rd[sl]--;
          end
          add_res(ST_RELEASED, sl, 0, 0, 1);
        end
      end
      OP_FLUSH: begin
        cur = m_head;
        for (int n = 0; n < m_len; n++) begin
          if (m_dirty[cur]) begin
            add_res(ST_FLUSH_ITEM, cur, m_tag[cur], 1, 0);
            m_dirty[cur] = 0;
          end
          cur = m_next[cur];
        end
        add_res(ST_FLUSH_DONE, 0, 0, 0, 1);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    n_err++;
  endtask

  // checker for results
  always @(posedge clk_i) begin
    cache_res_t e;
    if (rst_ni && valid_o) begin
      n_results++;
      idle_cyc = 0;
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result, status", status_o, 0);
      end else begin
        e = pending_res.pop_front();
        if (status_o != e.st) report_mismatch("status", status_o, e.st);
        if (slot_o != e.slot) report_mismatch("slot", slot_o, e.slot);
        if (victim_sector_o != e.vs) report_mismatch("victim_sector", victim_sector_o, e.vs);
        if (write_back_o != e.wb) report_mismatch("write_back", write_back_o, e.wb);
        if (last_o != e.last) report_mismatch("last", last_o, e.last);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cyc++;
      if (idle_cyc >= WD_LIMIT) begin
        timed_out = 1;
        $display("timeout: no transaction for %0d cycles", WD_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic issue(op_e op, logic [31:0] sec, bit wr, logic [5:0] sl,
                       bit typed = 0, status_e st = ST_HIT, logic [5:0] eslot = 0);
    if (idle_en && $urandom_range(99) < 10) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(6)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    op_i <= op;
    sector_i <= sec;
    for_write_i <= wr;
    slot_in_i <= sl;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    idle_cyc = 0;
    cache_predict(op, sec, wr, sl);
    if (op != OP_NONE) n_items++;
    foreach (step_res[i]) begin
      if (step_res[i].st == ST_FILL_EVICT) n_evict++;
      if (step_res[i].st == ST_STALL) n_stall++;
      if (step_res[i].st == ST_FLUSH_DONE) n_flush++;
    end
    if (typed) begin
      if (op != OP_NONE) begin
        step_res.delete();
        add_res(st, eslot, 0, 0, 1);
      end
    end
    foreach (step_res[i]) pending_res.push_back(step_res[i]);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  function automatic dir_row_t mk(op_e op, logic [31:0] sec, bit wr, int sl,
                                  bit typed = 0, status_e st = ST_HIT, int eslot = 0);
    dir_row_t r;
    r.op = op; r.sector = sec; r.wr = wr; r.slot = sl[5:0];
    r.typed = typed; r.st = st; r.eslot = eslot[5:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_sector();
    int k;
    logic [31:0] s;
    k = $urandom_range(99);
    if (k < 75) return $urandom_range(95);
    if (k < 85) return 32'hFFFF_FFFE - $urandom_range(3);
    s = $urandom;
    if (s == 32'hFFFF_FFFF) s = 32'hFFFF_FFFE;
    return s;
  endfunction

  // mostly a slot that currently holds a reference, sometimes any slot
  function automatic void pick_release(output logic [5:0] sl, output bit wr);
    int b;
    sl = $urandom_range(NSLOT - 1);
    wr = $urandom_range(1);
    if ($urandom_range(99) < 15) return;
    b = $urandom_range(NSLOT - 1);
    for (int i = 0; i < NSLOT; i++) begin
      int s;
      s = (b + i) % NSLOT;
      if (m_used[s] && (m_rd[s] + m_wr[s]) > 0) begin
        sl = s;
        if (m_rd[s] == 0) wr = 1;
        else if (m_wr[s] == 0) wr = 0;
        return;
      end
    end
  endfunction

  initial begin
    dir_row_t    rows[$];
    int          k;
    logic [5:0]  rsl;
    bit          rwr;
    logic [31:0] sec;

    start_i = 0; op_i = OP_NONE; sector_i = 0; for_write_i = 0; slot_in_i = 0;
    rst_ni = 0;
    for (int i = 0; i < NSLOT; i++) begin
      m_used[i] = 0; m_dirty[i] = 0; m_rd[i] = 0; m_wr[i] = 0; m_next[i] = 0; m_tag[i] = 0;
    end
    m_head = 0; m_tail = 0; m_len = 0; m_hand_v = 0; m_hand = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed part
    rows.push_back(mk(OP_FLUSH,   0, 0, 0,  1, ST_FLUSH_DONE, 0));
    rows.push_back(mk(OP_RELEASE, 0, 0, 0,  1, ST_REL_ERROR, 0));
    rows.push_back(mk(OP_RELEASE, 0, 1, 63, 1, ST_REL_ERROR, 63));
    rows.push_back(mk(OP_NONE,    32'hFFFF_FFFF, 1, 63, 1));
    rows.push_back(mk(OP_ACQUIRE, 0, 0, 0,  1, ST_FILL_FREE, 0));
    rows.push_back(mk(OP_ACQUIRE, 32'hFFFF_FFFE, 1, 0, 1, ST_FILL_FREE, 1));
    rows.push_back(mk(OP_ACQUIRE, 0, 1, 0,  1, ST_HIT, 0));
    rows.push_back(mk(OP_RELEASE, 0, 1, 0));
    rows.push_back(mk(OP_RELEASE, 0, 1, 0));
    rows.push_back(mk(OP_RELEASE, 0, 1, 0));
    rows.push_back(mk(OP_RELEASE, 0, 0, 1));
    rows.push_back(mk(OP_RELEASE, 0, 1, 1));
    rows.push_back(mk(OP_FLUSH,   0, 0, 0));
    rows.push_back(mk(OP_FLUSH,   0, 0, 0));
    rows.push_back(mk(OP_ACQUIRE, 32'hFFFF_FFFE, 0, 0));
    rows.push_back(mk(OP_ACQUIRE, 32'h8000_0001, 1, 0));
    rows.push_back(mk(OP_RELEASE, 0, 0, 1));
    rows.push_back(mk(OP_RELEASE, 0, 0, 1));
    rows.push_back(mk(OP_RELEASE, 0, 1, 2));
    rows.push_back(mk(OP_RELEASE, 0, 0, 0));
    rows.push_back(mk(OP_FLUSH,   0, 0, 0));
    foreach (rows[i])
      issue(rows[i].op, rows[i].sector, rows[i].wr, rows[i].slot,
            rows[i].typed, rows[i].st, rows[i].eslot);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    // fill every slot with a referenced sector, then a miss must stall
    idle_en = 0;
    for (int i = 0; i < NSLOT; i++) issue(OP_ACQUIRE, 32'h1000 + i, i % 2, 0);
    issue(OP_ACQUIRE, 32'h5555_AAAA, 0, 0);
    for (int i = 0; i < NSLOT; i++) issue(OP_RELEASE, 0, i % 2, i);
    // saturate one reader count: the acquires raise it to its maximum, and none of them stalls
    for (int i = 0; i < CNT_MAX; i++) issue(OP_ACQUIRE, 32'h1004, 0, 0);
    idle_en = 1;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    // random part
    for (int n = 0; n < 30; n++) begin
      if (n == 12) begin
        drain();
        repeat ($urandom_range(40)) @(posedge clk_i);
      end
      k = $urandom_range(99);
      if (k < 52) begin
        sec = rand_sector();
        issue(OP_ACQUIRE, sec, $urandom_range(1), $urandom_range(NSLOT - 1));
      end else if (k < 93) begin
        pick_release(rsl, rwr);
        issue(OP_RELEASE, $urandom, rwr, rsl);
      end else if (k < 98) begin
        issue(OP_FLUSH, $urandom, $urandom_range(1), $urandom_range(NSLOT - 1));
      end else begin
        issue(OP_NONE, $urandom, $urandom_range(1), $urandom_range(NSLOT - 1));
        n--;
      end
    end
    issue(OP_FLUSH, 0, 0, 0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("run covered %0d transactions, %0d results: %0d evictions, %0d stalls, %0d flushes",
             n_items, n_results, n_evict, n_stall, n_flush);
    $display("including empty-cache errors, all-referenced stall and a saturated count");
    if (n_err == 0 && pending_res.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", n_err, pending_res.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sbc_pkg.sv
src/sbc_ram.sv
src/sbc_ctrl.sv
src/sector_buffer_cache_manager_top.sv
dv/tb.sv
